// ----- rtl/core/motor_maneuver_sequencer_core_defines.svh -----
// assertion macros for the motor maneuver sequencer checker
`ifndef MOTOR_MANEUVER_SEQUENCER_CORE_DEFINES_SVH
`define MOTOR_MANEUVER_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/mms_pkg.sv -----
// types and constants for the motor maneuver sequencer
package mms_pkg;

  localparam int MODE_W  = 3;
  localparam int EVENT_W = 3;
  localparam int LEVEL_W = 7;
  localparam int TICK_W  = 8;
  localparam int SUM_W   = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int NUM_CH  = 4;

  localparam logic [MODE_W-1:0] MODE_STOP       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ACCEL      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FORWARD    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OBST_LEFT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OBST_RIGHT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MINE       = 3'd5;

  localparam logic [EVENT_W-1:0] EV_START      = 3'd1;
  localparam logic [EVENT_W-1:0] EV_STOP       = 3'd2;
  localparam logic [EVENT_W-1:0] EV_OBST_LEFT  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_OBST_RIGHT = 3'd4;
  localparam logic [EVENT_W-1:0] EV_MINE       = 3'd5;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_END    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_END     = 3'd5;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd100;
  localparam logic signed [SUM_W-1:0] LEVEL_FULL_S = 9'sd100;

  localparam logic signed [SUM_W-1:0] OFS_ACCEL_B   = 9'sd20;
  localparam logic signed [SUM_W-1:0] OFS_ACCEL_D   = 9'sd25;
  localparam logic signed [SUM_W-1:0] OFS_FORWARD_B = 9'sd14;
  localparam logic signed [SUM_W-1:0] OFS_REVERSE_A = 9'sd6;
  localparam logic signed [SUM_W-1:0] OFS_REVERSE_C = 9'sd1;

  localparam logic [LEVEL_W-1:0] RST_BASE_SPEED = 7'd49;
  localparam logic [TICK_W-1:0]  RST_ACCEL      = 8'd2;
  localparam logic [TICK_W-1:0]  RST_REVERSE    = 8'd30;
  localparam logic [TICK_W-1:0]  RST_PAUSE_END  = 8'd50;
  localparam logic [TICK_W-1:0]  RST_TURN_END   = 8'd65;

  typedef struct packed {
    logic               queue_enable;
    logic [LEVEL_W-1:0] base_speed;
    logic [TICK_W-1:0]  accel_ticks;
    logic [TICK_W-1:0]  reverse_ticks;
    logic [TICK_W-1:0]  pause_end_ticks;
    logic [TICK_W-1:0]  turn_end_ticks;
  } mms_cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]              mode;
    logic                           running;
    logic                           turn_right;
    logic [NUM_CH-1:0][LEVEL_W-1:0] level;
  } mms_ctl_t;

  typedef struct packed {
    logic rearm;
    logic cleared;
  } mms_pulse_t;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic signed [SUM_W-1:0] v);
    logic [LEVEL_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > LEVEL_FULL_S) begin
      res = LEVEL_FULL;
    end else begin
      res = v[LEVEL_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/mms_if.sv -----
// valid/ready channel interfaces for input and result transactions
interface mms_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [mms_pkg::EVENT_W-1:0] event_code;

  modport source (output valid, output opcode, output event_code, input ready);
  modport sink   (input valid, input opcode, input event_code, output ready);
endinterface

interface mms_out_if;
  logic                        valid;
  logic                        ready;
  logic [mms_pkg::MODE_W-1:0]  mode_now;
  logic                        motors_running;
  logic [mms_pkg::LEVEL_W-1:0] compare_one;
  logic [mms_pkg::LEVEL_W-1:0] compare_two;
  logic [mms_pkg::LEVEL_W-1:0] compare_three;
  logic [mms_pkg::LEVEL_W-1:0] compare_four;
  logic                        sensors_rearm;
  logic                        mine_cleared;

  modport source (output valid, output mode_now, output motors_running,
                  output compare_one, output compare_two, output compare_three,
                  output compare_four, output sensors_rearm, output mine_cleared,
                  input ready);
  modport sink   (input valid, input mode_now, input motors_running,
                  input compare_one, input compare_two, input compare_three,
                  input compare_four, input sensors_rearm, input mine_cleared,
                  output ready);
endinterface

// ----- rtl/core/mms_step.sv -----
// next-state logic for one tick or sequencer step
module mms_step #(
  parameter int DELAY_BITS = 8
) (
  input  logic                          opcode,
  input  logic [mms_pkg::EVENT_W-1:0]   event_code,
  input  mms_pkg::mms_cfg_t             cfg,
  input  mms_pkg::mms_ctl_t             ctl,
  input  logic [DELAY_BITS-1:0]         delay,
  output mms_pkg::mms_ctl_t             ctl_nxt,
  output logic [DELAY_BITS-1:0]         delay_nxt,
  output mms_pkg::mms_pulse_t           pulse
);

  localparam int CW = (DELAY_BITS > mms_pkg::TICK_W) ? DELAY_BITS : mms_pkg::TICK_W;

  logic signed [mms_pkg::SUM_W-1:0] bs;
  logic [CW-1:0] d_ext;
  logic [CW-1:0] accel_ext;
  logic [CW-1:0] reverse_ext;
  logic [CW-1:0] pause_ext;
  logic [CW-1:0] turn_ext;
  logic [mms_pkg::MODE_W-1:0] mode_ev;
  logic [DELAY_BITS-1:0] delay_ev;

  assign bs          = $signed({2'b00, cfg.base_speed});
  assign accel_ext   = CW'(cfg.accel_ticks);
  assign reverse_ext = CW'(cfg.reverse_ticks);
  assign pause_ext   = CW'(cfg.pause_end_ticks);
  assign turn_ext    = CW'(cfg.turn_end_ticks);

  // event intake ahead of the mode action
  always_comb begin
    mode_ev  = ctl.mode;
    delay_ev = delay;
    if (cfg.queue_enable) begin
      case (event_code)
        mms_pkg::EV_START: begin
          mode_ev  = mms_pkg::MODE_ACCEL;
          delay_ev = '0;
        end
        mms_pkg::EV_STOP: begin
          mode_ev = mms_pkg::MODE_STOP;
        end
        mms_pkg::EV_OBST_LEFT: begin
          mode_ev  = mms_pkg::MODE_OBST_LEFT;
          delay_ev = '0;
        end
        mms_pkg::EV_OBST_RIGHT: begin
          mode_ev  = mms_pkg::MODE_OBST_RIGHT;
          delay_ev = '0;
        end
        mms_pkg::EV_MINE: begin
          mode_ev  = mms_pkg::MODE_MINE;
          delay_ev = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign d_ext = CW'(delay_ev);

  always_comb begin
    ctl_nxt   = ctl;
    delay_nxt = delay;
    pulse     = '0;
    if (opcode == mms_pkg::OP_TICK) begin
      if (delay != {DELAY_BITS{1'b1}}) begin
        delay_nxt = delay + 1'b1;
      end
    end else begin
      ctl_nxt.mode = mode_ev;
      delay_nxt    = delay_ev;
      case (mode_ev)
        mms_pkg::MODE_STOP: begin
          ctl_nxt.running = 1'b0;
        end
        mms_pkg::MODE_ACCEL: begin
          if (d_ext <= accel_ext) begin
            ctl_nxt.level[0] = mms_pkg::LEVEL_FULL;
            ctl_nxt.level[1] = mms_pkg::clamp_level(bs - mms_pkg::OFS_ACCEL_B);
            ctl_nxt.level[2] = mms_pkg::LEVEL_FULL;
            ctl_nxt.level[3] = mms_pkg::clamp_level(bs - mms_pkg::OFS_ACCEL_D);
            ctl_nxt.running  = 1'b1;
          end else begin
            ctl_nxt.mode = mms_pkg::MODE_FORWARD;
          end
        end
        mms_pkg::MODE_FORWARD: begin
          ctl_nxt.level[0] = mms_pkg::LEVEL_FULL;
          ctl_nxt.level[1] = mms_pkg::clamp_level(bs + mms_pkg::OFS_FORWARD_B);
          ctl_nxt.level[2] = mms_pkg::LEVEL_FULL;
          ctl_nxt.level[3] = mms_pkg::clamp_level(bs);
          ctl_nxt.running  = 1'b1;
        end
        mms_pkg::MODE_OBST_LEFT, mms_pkg::MODE_OBST_RIGHT: begin
          if (d_ext < reverse_ext) begin
            ctl_nxt.level[0] = mms_pkg::clamp_level(bs + mms_pkg::OFS_REVERSE_A);
            ctl_nxt.level[1] = mms_pkg::LEVEL_FULL;
            ctl_nxt.level[2] = mms_pkg::clamp_level(bs - mms_pkg::OFS_REVERSE_C);
            ctl_nxt.level[3] = mms_pkg::LEVEL_FULL;
            ctl_nxt.running  = 1'b1;
          end else if (d_ext <= pause_ext) begin
            ctl_nxt.running = 1'b0;
            if (mode_ev == mms_pkg::MODE_OBST_RIGHT) begin
              ctl_nxt.level[0] = mms_pkg::LEVEL_FULL;
              ctl_nxt.level[1] = mms_pkg::clamp_level(bs);
              ctl_nxt.level[2] = mms_pkg::clamp_level(bs);
              ctl_nxt.level[3] = mms_pkg::LEVEL_FULL;
            end else begin
              ctl_nxt.level[0] = mms_pkg::clamp_level(bs);
              ctl_nxt.level[1] = mms_pkg::LEVEL_FULL;
              ctl_nxt.level[2] = mms_pkg::LEVEL_FULL;
              ctl_nxt.level[3] = mms_pkg::clamp_level(bs);
            end
          end else if (d_ext >= turn_ext) begin
            ctl_nxt.running = 1'b0;
            ctl_nxt.mode    = mms_pkg::MODE_ACCEL;
            delay_nxt       = '0;
            pulse.rearm     = 1'b1;
          end else begin
            ctl_nxt.running = 1'b1;
          end
        end
        mms_pkg::MODE_MINE: begin
          ctl_nxt.running = 1'b0;
          if (d_ext >= pause_ext) begin
            ctl_nxt.turn_right = ~ctl.turn_right;
            ctl_nxt.mode       = ctl.turn_right ? mms_pkg::MODE_OBST_LEFT
                                                : mms_pkg::MODE_OBST_RIGHT;
            delay_nxt          = '0;
            pulse.cleared      = 1'b1;
          end
        end
        default: begin
          ctl_nxt.mode    = mms_pkg::MODE_STOP;
          ctl_nxt.running = 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/motor_maneuver_sequencer_core.sv -----
// motor maneuver sequencer top level
// a result is registered in the cycle after its input transaction is accepted
// one transaction per cycle unless stalled; state and result registers update together
// input ready stays high while the result register is empty or being drained
// reset: synchronous active-low rst_n clears mode, delay count, levels and run flag,
// sets the turn direction and loads the configuration defaults
module motor_maneuver_sequencer_core #(
  parameter int DELAY_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  mms_in_if.sink                           in_chan,
  mms_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [mms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mms_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  mms_pkg::mms_cfg_t   cfg_r;
  mms_pkg::mms_ctl_t   ctl_r;
  mms_pkg::mms_ctl_t   ctl_nxt;
  mms_pkg::mms_pulse_t pulse_r;
  mms_pkg::mms_pulse_t pulse_nxt;
  logic [DELAY_BITS-1:0] delay_r;
  logic [DELAY_BITS-1:0] delay_nxt;
  logic out_valid_r;
  logic in_accept;

  assign in_chan.ready = ~out_valid_r | out_chan.ready;
  assign in_accept     = in_chan.valid & in_chan.ready;

  mms_step #(
    .DELAY_BITS(DELAY_BITS)
  ) u_step (
    .opcode     (in_chan.opcode),
    .event_code (in_chan.event_code),
    .cfg        (cfg_r),
    .ctl        (ctl_r),
    .delay      (delay_r),
    .ctl_nxt    (ctl_nxt),
    .delay_nxt  (delay_nxt),
    .pulse      (pulse_nxt)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.queue_enable    <= 1'b0;
      cfg_r.base_speed      <= mms_pkg::RST_BASE_SPEED;
      cfg_r.accel_ticks     <= mms_pkg::RST_ACCEL;
      cfg_r.reverse_ticks   <= mms_pkg::RST_REVERSE;
      cfg_r.pause_end_ticks <= mms_pkg::RST_PAUSE_END;
      cfg_r.turn_end_ticks  <= mms_pkg::RST_TURN_END;
    end else if (cfg_we) begin
      case (cfg_index)
        mms_pkg::CFG_QUEUE_ENABLE: cfg_r.queue_enable    <= cfg_wdata[0];
        mms_pkg::CFG_BASE_SPEED:   cfg_r.base_speed      <= cfg_wdata[mms_pkg::LEVEL_W-1:0];
        mms_pkg::CFG_ACCEL_TICKS:  cfg_r.accel_ticks     <= cfg_wdata;
        mms_pkg::CFG_REVERSE:      cfg_r.reverse_ticks   <= cfg_wdata;
        mms_pkg::CFG_PAUSE_END:    cfg_r.pause_end_ticks <= cfg_wdata;
        mms_pkg::CFG_TURN_END:     cfg_r.turn_end_ticks  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // sequencer state doubles as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.mode       <= mms_pkg::MODE_STOP;
      ctl_r.running    <= 1'b0;
      ctl_r.turn_right <= 1'b1;
      ctl_r.level      <= '0;
      delay_r          <= '0;
      pulse_r          <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (in_accept) begin
        ctl_r       <= ctl_nxt;
        delay_r     <= delay_nxt;
        pulse_r     <= pulse_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.mode_now       = ctl_r.mode;
  assign out_chan.motors_running = ctl_r.running;
  assign out_chan.compare_one    = ctl_r.level[0];
  assign out_chan.compare_two    = ctl_r.level[1];
  assign out_chan.compare_three  = ctl_r.level[2];
  assign out_chan.compare_four   = ctl_r.level[3];
  assign out_chan.sensors_rearm  = pulse_r.rearm;
  assign out_chan.mine_cleared   = pulse_r.cleared;

endmodule

// ----- rtl/core/mms_checker.sv -----
// port-level checker for the motor maneuver sequencer and its bind
`include "motor_maneuver_sequencer_core_defines.svh"

module mms_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mms_pkg::MODE_W-1:0]  mode_now,
  input logic                        motors_running,
  input logic [mms_pkg::LEVEL_W-1:0] compare_one,
  input logic [mms_pkg::LEVEL_W-1:0] compare_two,
  input logic [mms_pkg::LEVEL_W-1:0] compare_three,
  input logic [mms_pkg::LEVEL_W-1:0] compare_four,
  input logic                        sensors_rearm,
  input logic                        mine_cleared
);

  `MMS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(mode_now) && $stable(compare_one) && $stable(compare_four), "result changed while stalled")
  `MMS_ASSERT_NOW(a_level_range, clk, rst_n, out_valid, compare_one <= mms_pkg::LEVEL_FULL && compare_two <= mms_pkg::LEVEL_FULL && compare_three <= mms_pkg::LEVEL_FULL && compare_four <= mms_pkg::LEVEL_FULL, "compare level above full scale")
  `MMS_ASSERT_NOW(a_pulse_excl, clk, rst_n, out_valid, !(sensors_rearm && mine_cleared), "rearm and cleared pulses together")
  `MMS_ASSERT_NOW(a_cleared_mode, clk, rst_n, out_valid && mine_cleared, mode_now == mms_pkg::MODE_OBST_LEFT || mode_now == mms_pkg::MODE_OBST_RIGHT, "mine cleared without obstacle turn")
  `MMS_ASSERT_NOW(a_rearm_mode, clk, rst_n, out_valid && sensors_rearm, mode_now == mms_pkg::MODE_ACCEL && !motors_running, "rearm without stopped accelerate")

endmodule

bind motor_maneuver_sequencer_core mms_checker u_mms_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .mode_now       (out_chan.mode_now),
  .motors_running (out_chan.motors_running),
  .compare_one    (out_chan.compare_one),
  .compare_two    (out_chan.compare_two),
  .compare_three  (out_chan.compare_three),
  .compare_four   (out_chan.compare_four),
  .sensors_rearm  (out_chan.sensors_rearm),
  .mine_cleared   (out_chan.mine_cleared)
);

// ----- bench/motor_maneuver_sequencer_core_tb.sv -----
// self-checking testbench for the motor maneuver sequencer core
`timescale 1ns / 1ps

module motor_maneuver_sequencer_core_tb;

  localparam int DELAY_BITS   = 8;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_PHASE   = 6;
  localparam int HOLD_CYCLES  = 80;

  typedef logic [mms_pkg::EVENT_W-1:0] event_t;

  localparam event_t EV_NONE     = 3'd0;
  localparam event_t EV_SPARE_LO = 3'd6;
  localparam event_t EV_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [mms_pkg::MODE_W-1:0]  mode_now;
    logic                        motors_running;
    logic [mms_pkg::LEVEL_W-1:0] compare_one;
    logic [mms_pkg::LEVEL_W-1:0] compare_two;
    logic [mms_pkg::LEVEL_W-1:0] compare_three;
    logic [mms_pkg::LEVEL_W-1:0] compare_four;
    logic                        sensors_rearm;
    logic                        mine_cleared;
  } drive_state_t;

  class maneuver_tracker;
    mms_pkg::mms_cfg_t           regs;
    logic [mms_pkg::MODE_W-1:0]  mode;
    logic [DELAY_BITS-1:0]       delay;
    bit                          turn_right;
    logic [mms_pkg::LEVEL_W-1:0] level [mms_pkg::NUM_CH];
    bit                          running;
    drive_state_t                expected_drive [$];
    int mismatches, results, turns_done, mines_cleared, ceiling_ticks;

    function new();
      regs = '{queue_enable: 1'b0, base_speed: mms_pkg::RST_BASE_SPEED,
               accel_ticks: mms_pkg::RST_ACCEL, reverse_ticks: mms_pkg::RST_REVERSE,
               pause_end_ticks: mms_pkg::RST_PAUSE_END,
               turn_end_ticks: mms_pkg::RST_TURN_END};
      mode = mms_pkg::MODE_STOP;
      delay = '0;
      turn_right = 1'b1;
      foreach (level[i]) level[i] = '0;
      running = 1'b0;
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function logic [mms_pkg::LEVEL_W-1:0] clip(int v);
      if (v < 0) return '0;
      if (v > 100) return mms_pkg::LEVEL_FULL;
      return v[mms_pkg::LEVEL_W-1:0];
    endfunction

    function void load(int a, int b, int c, int d);
      level[0] = clip(a);
      level[1] = clip(b);
      level[2] = clip(c);
      level[3] = clip(d);
    endfunction

    function void set_reg(logic [mms_pkg::CFG_IDX_W-1:0] idx,
                          logic [mms_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mms_pkg::CFG_QUEUE_ENABLE: regs.queue_enable    = data[0];
        mms_pkg::CFG_BASE_SPEED:   regs.base_speed      = data[mms_pkg::LEVEL_W-1:0];
        mms_pkg::CFG_ACCEL_TICKS:  regs.accel_ticks     = data;
        mms_pkg::CFG_REVERSE:      regs.reverse_ticks   = data;
        mms_pkg::CFG_PAUSE_END:    regs.pause_end_ticks = data;
        mms_pkg::CFG_TURN_END:     regs.turn_end_ticks  = data;
        default: ;
      endcase
    endfunction

    function void take_item(logic op, event_t ev);
      drive_state_t d;
      int bs;
      bit rearm;
      bit cleared;
      bs = int'(regs.base_speed);
      rearm = 1'b0;
      cleared = 1'b0;
      if (op == mms_pkg::OP_TICK) begin
        if (delay != '1) delay++;
        else ceiling_ticks++;
      end else begin
        if (regs.queue_enable) begin
          case (ev)
            mms_pkg::EV_START:      begin mode = mms_pkg::MODE_ACCEL;      delay = '0; end
            mms_pkg::EV_STOP:       mode = mms_pkg::MODE_STOP;
            mms_pkg::EV_OBST_LEFT:  begin mode = mms_pkg::MODE_OBST_LEFT;  delay = '0; end
            mms_pkg::EV_OBST_RIGHT: begin mode = mms_pkg::MODE_OBST_RIGHT; delay = '0; end
            mms_pkg::EV_MINE:       begin mode = mms_pkg::MODE_MINE;       delay = '0; end
            default: ;
          endcase
        end
        case (mode)
          mms_pkg::MODE_STOP: running = 1'b0;
          mms_pkg::MODE_ACCEL: begin
            if (delay <= regs.accel_ticks) begin
              load(100, bs - 20, 100, bs - 25);
              running = 1'b1;
            end else begin
              mode = mms_pkg::MODE_FORWARD;
            end
          end
          mms_pkg::MODE_FORWARD: begin
            load(100, bs + 14, 100, bs);
            running = 1'b1;
          end
          mms_pkg::MODE_OBST_LEFT, mms_pkg::MODE_OBST_RIGHT: begin
            if (delay < regs.reverse_ticks) begin
              load(bs + 6, 100, bs - 1, 100);
              running = 1'b1;
            end else if (delay <= regs.pause_end_ticks) begin
              running = 1'b0;
              if (mode == mms_pkg::MODE_OBST_RIGHT) load(100, bs, bs, 100);
              else load(bs, 100, 100, bs);
            end else begin
              running = 1'b1;
              if (delay >= regs.turn_end_ticks) begin
                running = 1'b0;
                mode = mms_pkg::MODE_ACCEL;
                delay = '0;
                rearm = 1'b1;
                turns_done++;
              end
            end
          end
          mms_pkg::MODE_MINE: begin
            running = 1'b0;
            if (delay >= regs.pause_end_ticks) begin
              turn_right = !turn_right;
              mode = turn_right ? mms_pkg::MODE_OBST_RIGHT : mms_pkg::MODE_OBST_LEFT;
              delay = '0;
              cleared = 1'b1;
              mines_cleared++;
            end
          end
          default: begin
            mode = mms_pkg::MODE_STOP;
            running = 1'b0;
          end
        endcase
      end
      d.mode_now       = mode;
      d.motors_running = running;
      d.compare_one    = level[0];
      d.compare_two    = level[1];
      d.compare_three  = level[2];
      d.compare_four   = level[3];
      d.sensors_rearm  = rearm;
      d.mine_cleared   = cleared;
      expected_drive.push_back(d);
    endfunction

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("%s got %0d expected %0d (transaction %0d)", name, got, want,
                         results));
    endtask

    task compare_drive(drive_state_t got);
      drive_state_t want;
      if (expected_drive.size() == 0) begin
        report("result transaction with no input waiting");
        return;
      end
      want = expected_drive.pop_front();
      check_field("mode_now", 8'(got.mode_now), 8'(want.mode_now));
      check_field("motors_running", 8'(got.motors_running), 8'(want.motors_running));
      check_field("compare_one", 8'(got.compare_one), 8'(want.compare_one));
      check_field("compare_two", 8'(got.compare_two), 8'(want.compare_two));
      check_field("compare_three", 8'(got.compare_three), 8'(want.compare_three));
      check_field("compare_four", 8'(got.compare_four), 8'(want.compare_four));
      check_field("sensors_rearm", 8'(got.sensors_rearm), 8'(want.sensors_rearm));
      check_field("mine_cleared", 8'(got.mine_cleared), 8'(want.mine_cleared));
      results++;
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [mms_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mms_pkg::CFG_DATA_W-1:0] cfg_wdata;

  mms_in_if  in_chan ();
  mms_out_if out_chan ();

  motor_maneuver_sequencer_core #(.DELAY_BITS(DELAY_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  maneuver_tracker board;
  int send_idle_pct;
  int recv_idle_pct;
  int phase_no;
  int phase_budget;
  int sent_in_phase;
  int hold_left;
  bit hold_done;
  int cycle_count;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("motor_maneuver_sequencer_core regression: fail");
      $finish;
    end
  end

  // receiver, with one long hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (phase_no == HOLD_PHASE && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready)
      board.take_item(in_chan.opcode, in_chan.event_code);
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      board.compare_drive('{out_chan.mode_now, out_chan.motors_running,
                            out_chan.compare_one, out_chan.compare_two,
                            out_chan.compare_three, out_chan.compare_four,
                            out_chan.sensors_rearm, out_chan.mine_cleared});
  end

  function automatic mms_pkg::mms_cfg_t make_cfg(logic qe, int bs, int acc, int rev, int pau,
                                                 int turn);
    mms_pkg::mms_cfg_t c;
    c.queue_enable    = qe;
    c.base_speed      = bs[mms_pkg::LEVEL_W-1:0];
    c.accel_ticks     = acc[mms_pkg::TICK_W-1:0];
    c.reverse_ticks   = rev[mms_pkg::TICK_W-1:0];
    c.pause_end_ticks = pau[mms_pkg::TICK_W-1:0];
    c.turn_end_ticks  = turn[mms_pkg::TICK_W-1:0];
    return c;
  endfunction

  task automatic send_item(input logic op, input event_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.opcode     <= op;
    in_chan.event_code <= ev;
    do @(posedge clk); while (!in_chan.ready);
    sent_in_phase++;
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_settings(input mms_pkg::mms_cfg_t c);
    logic [mms_pkg::CFG_IDX_W-1:0]  idx  [6];
    logic [mms_pkg::CFG_DATA_W-1:0] data [6];
    idx  = '{mms_pkg::CFG_QUEUE_ENABLE, mms_pkg::CFG_BASE_SPEED, mms_pkg::CFG_ACCEL_TICKS,
             mms_pkg::CFG_REVERSE, mms_pkg::CFG_PAUSE_END, mms_pkg::CFG_TURN_END};
    data = '{{7'd0, c.queue_enable}, {1'b0, c.base_speed}, c.accel_ticks,
             c.reverse_ticks, c.pause_end_ticks, c.turn_end_ticks};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= data[i];
      @(posedge clk);
      board.set_reg(idx[i], data[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // one event, then ticks and plain steps with rare new events, or a random burst
  task automatic maneuver();
    int span;
    int ticks;
    event_t ev;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) send_item(1'($urandom_range(1)), event_t'($urandom_range(7)));
      return;
    end
    span = int'(board.regs.turn_end_ticks);
    if (int'(board.regs.pause_end_ticks) > span) span = int'(board.regs.pause_end_ticks);
    if (int'(board.regs.reverse_ticks) > span) span = int'(board.regs.reverse_ticks);
    if (int'(board.regs.accel_ticks) > span) span = int'(board.regs.accel_ticks);
    ticks = ($urandom_range(11) == 0) ? 270 : $urandom_range(0, span + 4);
    ev = event_t'($urandom_range(mms_pkg::EV_START, mms_pkg::EV_MINE));
    send_item(mms_pkg::OP_STEP, ev);
    repeat (ticks) begin
      if (sent_in_phase >= phase_budget) break;
      send_item(mms_pkg::OP_TICK, event_t'($urandom_range(7)));
      if ($urandom_range(2) == 0) begin
        ev = ($urandom_range(29) == 0) ? event_t'($urandom_range(7)) : EV_NONE;
        send_item(mms_pkg::OP_STEP, ev);
      end
    end
    repeat ($urandom_range(1, 3)) send_item(mms_pkg::OP_STEP, EV_NONE);
  endtask

  task automatic run_phase(input mms_pkg::mms_cfg_t c, input int budget, input int send_pct,
                           input int recv_pct);
    settle();
    phase_no++;
    write_settings(c);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent_in_phase = 0;
    phase_budget = budget;
    while (sent_in_phase < budget) maneuver();
  endtask

  initial begin
    int total;
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.opcode = mms_pkg::OP_TICK;
    in_chan.event_code = EV_NONE;
    send_idle_pct = 31;
    recv_idle_pct = 57;
    phase_no = 0;
    phase_budget = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // events are ignored while the queue is disabled after reset
    send_item(mms_pkg::OP_STEP, mms_pkg::EV_START);
    send_item(mms_pkg::OP_TICK, mms_pkg::EV_MINE);
    settle();
    write_settings(make_cfg(1'b1, int'(mms_pkg::RST_BASE_SPEED), int'(mms_pkg::RST_ACCEL),
                            int'(mms_pkg::RST_REVERSE), int'(mms_pkg::RST_PAUSE_END),
                            int'(mms_pkg::RST_TURN_END)));
    send_item(mms_pkg::OP_STEP, mms_pkg::EV_START);
    repeat (3) send_item(mms_pkg::OP_TICK, EV_NONE);
    send_item(mms_pkg::OP_STEP, EV_NONE);
    send_item(mms_pkg::OP_STEP, EV_NONE);
    send_item(mms_pkg::OP_STEP, EV_SPARE_LO);
    send_item(mms_pkg::OP_STEP, EV_SPARE_HI);
    send_item(mms_pkg::OP_STEP, EV_NONE);
    send_item(mms_pkg::OP_STEP, mms_pkg::EV_OBST_LEFT);
    send_item(mms_pkg::OP_STEP, mms_pkg::EV_OBST_RIGHT);
    send_item(mms_pkg::OP_STEP, mms_pkg::EV_MINE);
    send_item(mms_pkg::OP_TICK, EV_SPARE_HI);
    send_item(mms_pkg::OP_STEP, mms_pkg::EV_STOP);
    send_item(mms_pkg::OP_STEP, mms_pkg::EV_START);
    send_item(mms_pkg::OP_TICK, mms_pkg::EV_STOP);

    run_phase(make_cfg(1'b1, 25, 0, 1, 1, 1), 250, 31, 57);
    run_phase(make_cfg(1'b1, 86, 255, 255, 255, 255), 500, 31, 57);
    run_phase(make_cfg(1'b1, 60, 5, 8, 14, 20), 300, 57, 31);
    // thresholds out of order
    run_phase(make_cfg(1'b1, 33, 3, 20, 10, 6), 300, 57, 31);
    run_phase(make_cfg(1'b0, 70, 4, 3, 6, 9), 100, 0, 0);
    run_phase(make_cfg(1'b1, $urandom_range(25, 86), $urandom_range(0, 12),
                       $urandom_range(1, 20), $urandom_range(1, 40), $urandom_range(1, 60)),
              450, 0, 0);

    settle();
    repeat (3) @(posedge clk);
    if (board.pending() != 0) board.report("input transactions left without a result");
    total = board.results;
    $display("checked %0d result transactions over %0d register settings", total,
             phase_no + 2);
    $display("turns completed %0d, mine waits cleared %0d, ticks at the delay ceiling %0d",
             board.turns_done, board.mines_cleared, board.ceiling_ticks);
    if (board.mismatches == 0) begin
      $display("motor_maneuver_sequencer_core regression: pass");
    end else begin
      $display("motor_maneuver_sequencer_core regression: fail");
    end
    $finish;
  end

endmodule
